>>> sv/text_cell_frame_buffer_core_assert.svh
// Assertion macros shared by the frame buffer checkers.
`ifndef TEXT_CELL_FRAME_BUFFER_CORE_ASSERT_SVH
`define TEXT_CELL_FRAME_BUFFER_CORE_ASSERT_SVH

// Clocked check that is switched off while reset is high.
`define TCFB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("frame buffer check failed");

// Clocked check that also holds across reset.
`define TCFB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("frame buffer reset check failed");

`endif

>>> sv/tcfb_pkg.sv
// Types and codes shared by the text cell frame buffer modules.
`default_nettype none

package tcfb_pkg;

  // Request codes.
  localparam logic [2:0] REQ_DRAW  = 3'd0;
  localparam logic [2:0] REQ_FILL  = 3'd1;
  localparam logic [2:0] REQ_SHIFT = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_READ  = 3'd4;

  // Result status codes.
  localparam logic [1:0] ST_DONE     = 2'd0;
  localparam logic [1:0] ST_REJECT   = 2'd1;
  localparam logic [1:0] ST_NOCHANGE = 2'd2;

  // Internal command codes between the front end and the executor.
  localparam logic [1:0] CMD_FILL   = 2'd0;
  localparam logic [1:0] CMD_SHIFT  = 2'd1;
  localparam logic [1:0] CMD_READ   = 2'd2;
  localparam logic [1:0] CMD_REPORT = 2'd3;

  // Wide enough for the largest grid of 255 by 255 cells.
  localparam int IDX_BITS = 16;
  // Command queue depth, a power of two.
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [7:0]  end_col;
    logic [7:0]  end_row;
    logic [11:0] shift_cells;
    logic [15:0] cell_value;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cell_data;
  } rsp_t;

  typedef struct packed {
    logic [1:0]          op;
    logic [1:0]          status;
    logic [IDX_BITS-1:0] first;
    logic [IDX_BITS-1:0] last;
    logic [15:0]         value;
  } cmd_t;

endpackage

`default_nettype wire

>>> sv/text_cell_frame_buffer_core.sv
// A request passes the decoder and the command queue to the executor. Rejected and no-op
// requests yield a status result only; draw, fill and clear walk their runs of cells, read
// fetches one cell, shift by k copies the COLS*ROWS - k cells from k on; each walk touches
// one cell of the memory per cycle. A command starts the cycle after the previous result
// transfer, so the executor runs one command at a time. After reset a clearing pass
// writes zero to all COLS*ROWS cells, one per cycle, with req_ready low meanwhile.
`default_nettype none

module text_cell_frame_buffer_core
  import tcfb_pkg::*;
#(
  parameter int COLS      = 80,
  parameter int ROWS      = 25,
  parameter int CELL_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  // The front end checks coordinates and turns each request into one of
  // four internal commands: fill a linear run (draw, fill and clear all
  // become runs), shift, read, or report a status with no memory work.
  cmd_t front_cmd;
  logic front_push;

  // Queue state seen by both sides.
  cmd_t q_cmd;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // Low while the post-reset clearing pass runs.
  logic init_done;

  tcfb_front #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_front (
    .req       (req),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .init_done (init_done),
    .q_full    (q_full),
    .push      (front_push),
    .cmd       (front_cmd)
  );

  // The queue lets the front end keep taking request transfers while the
  // executor is busy walking the memory.
  tcfb_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (front_push),
    .wr_cmd (front_cmd),
    .full   (q_full),
    .pop    (q_pop),
    .rd_cmd (q_cmd),
    .valid  (q_valid)
  );

  // The executor owns the cell memory. It takes a new command only when its
  // result register is empty, so each request produces exactly one result
  // transfer, in order.
  tcfb_back #(
    .COLS      (COLS),
    .ROWS      (ROWS),
    .CELL_BITS (CELL_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (q_cmd),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .init_done (init_done),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire

>>> sv/tcfb_front.sv
// Request decoder: range checks, linear indices and command build.
`default_nettype none

module tcfb_front
  import tcfb_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  req_t req,
  input  logic req_valid,
  output logic req_ready,
  input  logic init_done,
  input  logic q_full,
  output logic push,
  output cmd_t cmd
);

  localparam logic [16:0] CELL_N = 17'(COLS * ROWS);

  logic [16:0] first_lin;
  logic [16:0] last_lin;
  logic        start_ok;
  logic        end_ok;

  assign req_ready = init_done && !q_full;
  assign push      = req_valid && req_ready;

  always_comb begin
    first_lin = 17'(req.col) + 17'(COLS) * 17'(req.row);
    last_lin  = 17'(req.end_col) + 17'(COLS) * 17'(req.end_row);
    start_ok  = (9'(req.col) < 9'(COLS)) && (9'(req.row) < 9'(ROWS));
    end_ok    = (9'(req.end_col) < 9'(COLS)) && (9'(req.end_row) < 9'(ROWS));

    cmd        = '0;
    cmd.op     = CMD_REPORT;
    cmd.status = ST_NOCHANGE;
    case (req.req_type)
      REQ_DRAW: begin
        if (start_ok) begin
          cmd.op    = CMD_FILL;
          cmd.first = first_lin[IDX_BITS-1:0];
          cmd.last  = first_lin[IDX_BITS-1:0];
          cmd.value = req.cell_value;
        end else begin
          cmd.status = ST_REJECT;
        end
      end
      REQ_FILL: begin
        if (!(start_ok && end_ok)) begin
          cmd.status = ST_REJECT;
        end else if (first_lin <= last_lin) begin
          cmd.op    = CMD_FILL;
          cmd.first = first_lin[IDX_BITS-1:0];
          cmd.last  = last_lin[IDX_BITS-1:0];
          cmd.value = req.cell_value;
        end
      end
      REQ_SHIFT: begin
        if (17'(req.shift_cells) < CELL_N) begin
          cmd.op    = CMD_SHIFT;
          cmd.first = IDX_BITS'(req.shift_cells);
        end
      end
      REQ_CLEAR: begin
        cmd.op    = CMD_FILL;
        cmd.first = '0;
        cmd.last  = IDX_BITS'(CELL_N - 17'd1);
        cmd.value = '0;
      end
      REQ_READ: begin
        if (start_ok) begin
          cmd.op    = CMD_READ;
          cmd.first = first_lin[IDX_BITS-1:0];
        end else begin
          cmd.status = ST_REJECT;
        end
      end
      default: begin
        cmd.status = ST_NOCHANGE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/tcfb_queue.sv
// Short command queue between the decoder and the executor.
`default_nettype none

module tcfb_queue
  import tcfb_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t wr_cmd,
  output logic full,
  input  logic pop,
  output cmd_t rd_cmd,
  output logic valid
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  cmd_t          slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign valid  = (count != '0);
  assign full   = (count == (PW + 1)'(QUEUE_DEPTH));
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/tcfb_back.sv
// Executor: cell memory, walk sequencer and result register.
`default_nettype none

module tcfb_back
  import tcfb_pkg::*;
#(
  parameter int COLS      = 80,
  parameter int ROWS      = 25,
  parameter int CELL_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  logic cmd_valid,
  output logic cmd_pop,
  output logic init_done,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int N  = COLS * ROWS;
  localparam int IW = (N > 1) ? $clog2(N) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(N - 1);

  localparam logic [2:0] S_INIT  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FILL  = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0]           state;
  logic [IW-1:0]        walk;
  logic [IW-1:0]        last;
  logic [IW-1:0]        src;
  logic                 src_more;
  logic                 rd_live;
  logic [CELL_BITS-1:0] fill_val;

  logic [CELL_BITS-1:0] mem [N];
  logic [CELL_BITS-1:0] rd_q;
  logic [IW-1:0]        rd_addr;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  logic [CELL_BITS-1:0] wr_data;

  assign init_done = (state != S_INIT);

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = walk;
    wr_data = fill_val;
    rd_addr = src;
    cmd_pop = 1'b0;
    case (state)
      S_INIT: begin
        wr_en   = 1'b1;
        wr_data = '0;
      end
      S_IDLE: begin
        rd_addr = cmd.first[IW-1:0];
        cmd_pop = cmd_valid && !rsp_valid;
      end
      S_FILL: begin
        wr_en = 1'b1;
      end
      S_SHIFT: begin
        wr_en   = rd_live;
        wr_data = rd_q;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      walk      <= '0;
      src_more  <= 1'b0;
      rd_live   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_INIT: begin
          if (walk == LAST_IDX) begin
            walk  <= '0;
            state <= S_IDLE;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_IDLE: begin
          if (cmd_pop) begin
            case (cmd.op)
              CMD_FILL: begin
                walk     <= cmd.first[IW-1:0];
                last     <= cmd.last[IW-1:0];
                fill_val <= CELL_BITS'(cmd.value);
                state    <= S_FILL;
              end
              CMD_SHIFT: begin
                walk     <= '0;
                src      <= cmd.first[IW-1:0];
                src_more <= 1'b1;
                rd_live  <= 1'b0;
                state    <= S_SHIFT;
              end
              CMD_READ: begin
                state <= S_READ;
              end
              default: begin
                rsp_valid     <= 1'b1;
                rsp.status    <= cmd.status;
                rsp.cell_data <= '0;
              end
            endcase
          end
        end
        S_FILL: begin
          if (walk == last) begin
            walk          <= '0;
            rsp_valid     <= 1'b1;
            rsp.status    <= ST_DONE;
            rsp.cell_data <= '0;
            state         <= S_IDLE;
          end else begin
            walk <= walk + 1'b1;
          end
        end
        S_SHIFT: begin
          // Reads run one cell ahead of the writes they feed.
          if (src_more) begin
            if (src == LAST_IDX) begin
              src_more <= 1'b0;
            end else begin
              src <= src + 1'b1;
            end
          end
          rd_live <= src_more;
          if (rd_live) begin
            walk <= walk + 1'b1;
          end
          if (!src_more && !rd_live) begin
            walk          <= '0;
            rsp_valid     <= 1'b1;
            rsp.status    <= ST_DONE;
            rsp.cell_data <= '0;
            state         <= S_IDLE;
          end
        end
        S_READ: begin
          rsp_valid     <= 1'b1;
          rsp.status    <= ST_DONE;
          rsp.cell_data <= 16'(rd_q);
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/tcfb_checker.sv
// Port-level checks for the frame buffer core and the bind that attaches them.
`default_nettype none

`include "text_cell_frame_buffer_core_assert.svh"

module tcfb_checker
  import tcfb_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp
);

  `TCFB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid)
  `TCFB_ASSERT(a_rsp_stable, rsp_valid && !rsp_ready |=> $stable(rsp))
  `TCFB_ASSERT(a_data_only_done, rsp_valid && rsp.status != ST_DONE |-> rsp.cell_data == '0)
  `TCFB_ASSERT_ALWAYS(a_clear_pass, rst |=> !req_ready)

endmodule

bind text_cell_frame_buffer_core tcfb_checker u_tcfb_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp       (rsp)
);

`default_nettype wire
